@@ hdl/sipq_pkg.sv @@
// ----------------------------------------------------------------------------
// sipq_pkg
// Shared types and codes of the sorted-insert priority queue.
// ----------------------------------------------------------------------------
package sipq_pkg;

    // operation codes carried on the input tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned FILL_W = 5;

    // one result word, fields in tdata order from the highest bit down
    typedef struct packed {
        logic [FILL_W-1:0]        fill_count;
        logic signed [DATA_W-1:0] read_data;
        logic [1:0]               status;
    } t_result;

endpackage

@@ hdl/sorted_insert_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_core
// Priority store kept sorted high to low in one synchronous memory.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one command word: tuser is the op (0 insert, 1 read),
//   tdata holds priority_in and read_index. m_axis returns exactly one
//   result word per command: status, read_data and fill_count.
// operation:
//   one command is worked at a time; s_axis_tready is high only while the
//   controller is idle. a read goes through accept, memory read and finish;
//   an insert walks from the tail and moves each stored entry lower than
//   the new value up one place, one entry per cycle, then writes the new
//   value and finishes. rejected commands (full store, index out of range)
//   go from accept straight to finish.
// reset:
//   the entry count clears to zero; the memory itself is not cleared, a
//   read only reaches positions below the count, which were all written.
// stall:
//   the result sits in an output register; the next command is accepted
//   while it waits, and the controller holds its finished result until
//   the output register frees up.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue_core
    import sipq_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] priority_in, [19:16] read_index, zero fill
    input  logic        s_axis_tuser,   // [0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // [1:0] status, [17:2] read_data, [22:18] fill_count
);

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_RWAIT = 5'b00010,
        S_SCAN  = 5'b00100,
        S_PLACE = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    // sorted store, position 0 holds the highest priority
    logic signed [DATA_W-1:0] mem [CAPACITY];

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [AW-1:0]            r_pos, n_pos;
    logic signed [DATA_W-1:0] r_value, n_value;
    t_result                  r_res, n_res;
    logic signed [DATA_W-1:0] r_rd_data;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr;
    logic signed [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]            mem_raddr;

    logic                     in_fire;
    logic                     out_free;
    logic                     out_load;
    logic signed [DATA_W-1:0] in_prio;
    logic [CW+3:0]            idx_ext;
    logic [CW+3:0]            cnt_ext;
    logic [CW+4:0]            fill_now_ext;
    logic [CW+4:0]            fill_inc_ext;
    logic [CW-1:0]            count_inc;
    t_result                  out_res;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_prio       = s_axis_tdata[15:0];

    // operands widened so index, count and capacity compare at one width
    assign idx_ext      = {{CW{1'b0}}, s_axis_tdata[19:16]};
    assign cnt_ext      = {4'd0, r_count};
    assign count_inc    = r_count + CW'(1);
    assign fill_now_ext = {5'd0, r_count};
    assign fill_inc_ext = {5'd0, count_inc};

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_pos     = r_pos;
        n_value   = r_value;
        n_res     = r_res;
        mem_we    = 1'b0;
        mem_waddr = r_pos;
        mem_wdata = r_value;
        mem_raddr = r_pos - AW'(1);
        out_load  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_value = in_prio;
                    if (s_axis_tuser == OP_INSERT) begin
                        if (cnt_ext == (CW+4)'(CAPACITY)) begin
                            n_res   = '{fill_count: fill_now_ext[FILL_W-1:0],
                                        read_data: '0, status: ST_FULL};
                            n_state = S_FIN;
                        end else if (r_count == '0) begin
                            n_pos   = '0;
                            n_state = S_PLACE;
                        end else begin
                            // fetch the tail entry and walk down from there
                            mem_raddr = r_count[AW-1:0] - AW'(1);
                            n_pos     = r_count[AW-1:0];
                            n_state   = S_SCAN;
                        end
                    end else begin
                        if ((idx_ext < cnt_ext) && (idx_ext < (CW+4)'(CAPACITY))) begin
                            mem_raddr = idx_ext[AW-1:0];
                            n_state   = S_RWAIT;
                        end else begin
                            n_res   = '{fill_count: fill_now_ext[FILL_W-1:0],
                                        read_data: '0, status: ST_RANGE};
                            n_state = S_FIN;
                        end
                    end
                end
            end

            S_RWAIT: begin
                n_res   = '{fill_count: fill_now_ext[FILL_W-1:0],
                            read_data: r_rd_data, status: ST_OK};
                n_state = S_FIN;
            end

            S_SCAN: begin
                // r_rd_data holds entry r_pos-1
                if (r_rd_data < r_value) begin
                    // lower entry moves up one place; prefetch the next one down
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = r_rd_data;
                    mem_raddr = r_pos - AW'(2);
                    n_pos     = r_pos - AW'(1);
                    if (r_pos == AW'(1)) begin
                        n_state = S_PLACE;
                    end
                end else begin
                    // greater or equal entry found, new value lands just after it
                    mem_we    = 1'b1;
                    mem_waddr = r_pos;
                    mem_wdata = r_value;
                    n_count   = count_inc;
                    n_res     = '{fill_count: fill_inc_ext[FILL_W-1:0],
                                  read_data: '0, status: ST_OK};
                    n_state   = S_FIN;
                end
            end

            S_PLACE: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_value;
                n_count   = count_inc;
                n_res     = '{fill_count: fill_inc_ext[FILL_W-1:0],
                              read_data: '0, status: ST_OK};
                n_state   = S_FIN;
            end

            S_FIN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_value <= n_value;
        r_res   <= n_res;
    end

    // store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[mem_raddr];
    end

    sipq_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (out_load),
        .i_result (r_res),
        .o_free   (out_free),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_res)
    );

    assign m_axis_tdata = {1'b0, out_res};

endmodule

@@ hdl/sipq_out_reg.sv @@
// ----------------------------------------------------------------------------
// sipq_out_reg
// Output register holding one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module sipq_out_reg
    import sipq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    // slot is free when empty or being drained this cycle
    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
